// ===== rtl/thsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thsp_pkg
// Shared types and constants for the ustar header stream parser.
// ----------------------------------------------------------------------------
package thsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TDATA_W         = 160;

    localparam int BLOCK_SHIFT = 9;
    localparam int REC_W       = 37;
    localparam int SIZE_W      = 36;
    localparam int BLK_W       = 28;

    localparam logic [8:0] LAST_HDR_POS = 9'd511;
    localparam logic [8:0] MODE_POS     = 9'd100;
    localparam logic [8:0] UID_POS      = 9'd108;
    localparam logic [8:0] GID_POS      = 9'd116;
    localparam logic [8:0] SIZE_POS     = 9'd124;
    localparam logic [8:0] SIZE_END     = 9'd136;
    localparam logic [8:0] TYPE_POS     = 9'd156;
    localparam logic [8:0] MAGIC_POS    = 9'd257;
    localparam logic [8:0] VER_POS      = 9'd263;
    localparam logic [8:0] VER_END      = 9'd265;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    localparam logic [11:0] PERM_MASK = 12'o6777;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STOP    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_VER   = 3'd2,
        ST_PAST_END  = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    localparam logic [2:0] ET_REGULAR = 3'd0;
    localparam logic [2:0] ET_UNKNOWN = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        status;
        logic [2:0]        etype;
        logic [11:0]       perm;
        logic [31:0]       uid;
        logic [31:0]       gid;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  blocks;
        logic [7:0]        pbyte;
        logic              plast;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    extra_stop;   // an exhausted stop follows this item
    } q_entry_t;

    function automatic result_t stop_result(input logic [2:0] code);
        result_t r;
        r        = '0;
        r.kind   = KIND_STOP;
        r.status = code;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/thsp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thsp_front
// Accepts archive bytes, tracks header/data phase and builds result entries.
// ----------------------------------------------------------------------------
module thsp_front #(
    parameter int LENGTH_BITS = thsp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              q_full,
    output logic                   q_wr,
    output thsp_pkg::q_entry_t     q_wdata
);
    import thsp_pkg::*;

    localparam int CMP_W = (LENGTH_BITS > REC_W) ? LENGTH_BITS : REC_W;

    phase_t                  phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]  left_reg, left_next;
    logic [8:0]              pos_reg, pos_next;
    logic [REC_W-1:0]        rec_reg, rec_next;
    logic [REC_W-1:0]        off_reg, off_next;
    logic [11:0]             mode_reg, mode_next;
    logic [31:0]             uid_reg, uid_next;
    logic [31:0]             gid_reg, gid_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic                    fd_reg, fd_next;
    logic                    magic_reg, magic_next;
    logic                    ver_reg, ver_next;
    logic [7:0]              type_reg, type_next;

    logic                    acc;
    logic [7:0]              b;
    logic [LENGTH_BITS-1:0]  left_dec;
    logic                    left_short, dec_short;
    logic                    is_reg, is_link;
    logic [BLK_W-1:0]        blocks;
    logic [REC_W-1:0]        rec_bytes;
    logic                    past_end;
    logic [2:0]              etype;
    logic                    fd_cur, term;
    logic [7:0]              magic_ch;
    logic                    in_field;

    assign s_tready   = !q_full;
    assign acc        = s_tvalid && s_tready;
    assign b          = s_tdata;
    assign left_dec   = left_reg - LENGTH_BITS'(1);
    assign left_short = (left_reg >> BLOCK_SHIFT) == '0;
    assign dec_short  = (left_dec >> BLOCK_SHIFT) == '0;
    assign is_reg     = (type_reg == CH_NUL) || (type_reg == CH_ZERO) || (type_reg == CH_SEVEN);
    assign is_link    = (type_reg >= CH_ONE) && (type_reg <= CH_SIX);
    assign blocks     = is_link ? '0
                      : BLK_W'(({1'b0, size_reg} + (REC_W)'(511)) >> BLOCK_SHIFT);
    assign rec_bytes  = {blocks, 9'd0};
    assign past_end   = CMP_W'(rec_bytes) > CMP_W'(left_dec);
    assign etype      = is_reg ? ET_REGULAR : (is_link ? type_reg[2:0] : ET_UNKNOWN);
    assign term       = (b == CH_NUL) || (b == CH_SPACE);
    assign in_field   = (pos_reg >= MODE_POS) && (pos_reg < SIZE_END);
    assign fd_cur     = (pos_reg == MODE_POS || pos_reg == UID_POS || pos_reg == GID_POS
                         || pos_reg == SIZE_POS) ? 1'b0 : fd_reg;

    always_comb
    begin
        unique case (pos_reg)
            MAGIC_POS:          magic_ch = "u";
            MAGIC_POS + 9'd1:   magic_ch = "s";
            MAGIC_POS + 9'd2:   magic_ch = "t";
            MAGIC_POS + 9'd3:   magic_ch = "a";
            MAGIC_POS + 9'd4:   magic_ch = "r";
            default:            magic_ch = CH_NUL;
        endcase
    end

    // next state and datapath
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        rec_next   = rec_reg;
        off_next   = off_reg;
        mode_next  = mode_reg;
        uid_next   = uid_reg;
        gid_next   = gid_reg;
        size_next  = size_reg;
        fd_next    = fd_reg;
        magic_next = magic_reg;
        ver_next   = ver_reg;
        type_next  = type_reg;
        if (cfg_we)
        begin
            phase_next = PH_HEADER;
            left_next  = LENGTH_BITS'(cfg_wdata);
            pos_next   = '0;
            rec_next   = '0;
            off_next   = '0;
            mode_next  = '0;
            uid_next   = '0;
            gid_next   = '0;
            size_next  = '0;
            fd_next    = 1'b0;
            magic_next = 1'b1;
            ver_next   = 1'b1;
            type_next  = '0;
        end
        else if (acc)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    rec_next  = rec_reg - REC_W'(1);
                    off_next  = off_reg + REC_W'(1);
                    left_next = left_dec;
                    if (rec_reg == REC_W'(1))
                    begin
                        pos_next   = '0;
                        phase_next = dec_short ? PH_STOP : PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    if (pos_reg == '0 && left_short)
                        phase_next = PH_STOP;
                    else
                    begin
                        if (pos_reg == '0)
                        begin
                            mode_next  = '0;
                            uid_next   = '0;
                            gid_next   = '0;
                            size_next  = '0;
                            fd_next    = 1'b0;
                            magic_next = 1'b1;
                            ver_next   = 1'b1;
                            type_next  = '0;
                        end
                        if (in_field)
                        begin
                            fd_next = fd_cur || term;
                            if (!fd_cur && !term)
                            begin
                                if (pos_reg < UID_POS)
                                    mode_next = {mode_reg[8:0], 3'b0} + {4'b0, b} - 12'd48;
                                else if (pos_reg < GID_POS)
                                    uid_next = {uid_reg[28:0], 3'b0} + {24'b0, b} - 32'd48;
                                else if (pos_reg < SIZE_POS)
                                    gid_next = {gid_reg[28:0], 3'b0} + {24'b0, b} - 32'd48;
                                else
                                    size_next = {size_reg[SIZE_W-4:0], 3'b0}
                                              + SIZE_W'(b) - SIZE_W'(48);
                            end
                        end
                        if (pos_reg == TYPE_POS)
                            type_next = b;
                        if (pos_reg >= MAGIC_POS && pos_reg < VER_POS && b != magic_ch)
                            magic_next = 1'b0;
                        if (pos_reg >= VER_POS && pos_reg < VER_END && b != CH_ZERO)
                            ver_next = 1'b0;
                        left_next = left_dec;
                        if (pos_reg != LAST_HDR_POS)
                            pos_next = pos_reg + 9'd1;
                        else
                        begin
                            pos_next = '0;
                            if (!magic_reg || !ver_reg || past_end)
                                phase_next = PH_STOP;
                            else if (blocks != '0)
                            begin
                                phase_next = PH_DATA;
                                rec_next   = rec_bytes;
                                off_next   = '0;
                            end
                            else if (dec_short)
                                phase_next = PH_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // queue write
    always_comb
    begin
        q_wr    = 1'b0;
        q_wdata = '0;
        if (acc && !cfg_we)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    if (is_reg && off_reg < REC_W'(size_reg))
                    begin
                        q_wr                   = 1'b1;
                        q_wdata.res.kind       = KIND_PAYLOAD;
                        q_wdata.res.pbyte      = b;
                        q_wdata.res.plast      = (off_reg + REC_W'(1)) == REC_W'(size_reg);
                        q_wdata.extra_stop     = (rec_reg == REC_W'(1)) && dec_short;
                    end
                    else if (rec_reg == REC_W'(1) && dec_short)
                    begin
                        q_wr        = 1'b1;
                        q_wdata.res = stop_result(ST_EXHAUSTED);
                    end
                end
                PH_HEADER:
                begin
                    if (pos_reg == '0 && left_short)
                    begin
                        q_wr        = 1'b1;
                        q_wdata.res = stop_result(ST_EXHAUSTED);
                    end
                    else if (pos_reg == LAST_HDR_POS)
                    begin
                        q_wr = 1'b1;
                        priority if (!magic_reg)
                            q_wdata.res = stop_result(ST_BAD_MAGIC);
                        else if (!ver_reg)
                            q_wdata.res = stop_result(ST_BAD_VER);
                        else if (past_end)
                            q_wdata.res = stop_result(ST_PAST_END);
                        else
                        begin
                            q_wdata.res.kind   = KIND_HEADER;
                            q_wdata.res.etype  = etype;
                            q_wdata.res.perm   = mode_reg & PERM_MASK;
                            q_wdata.res.uid    = uid_reg;
                            q_wdata.res.gid    = gid_reg;
                            q_wdata.res.size   = size_reg;
                            q_wdata.res.blocks = blocks;
                            q_wdata.extra_stop = (blocks == '0) && dec_short;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= '0;
            pos_reg   <= '0;
            rec_reg   <= '0;
            off_reg   <= '0;
            mode_reg  <= '0;
            uid_reg   <= '0;
            gid_reg   <= '0;
            size_reg  <= '0;
            fd_reg    <= 1'b0;
            magic_reg <= 1'b1;
            ver_reg   <= 1'b1;
            type_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            rec_reg   <= rec_next;
            off_reg   <= off_next;
            mode_reg  <= mode_next;
            uid_reg   <= uid_next;
            gid_reg   <= gid_next;
            size_reg  <= size_next;
            fd_reg    <= fd_next;
            magic_reg <= magic_next;
            ver_reg   <= ver_next;
            type_reg  <= type_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/thsp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thsp_queue
// Short result queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
module thsp_queue #(
    parameter int QUEUE_DEPTH = thsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr,
    input  wire thsp_pkg::q_entry_t wdata,
    input  wire logic               rd,
    output thsp_pkg::q_entry_t      rdata,
    output logic                    full,
    output logic                    empty
);
    import thsp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
            wp_next = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
        if (rd)
            rp_next = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
        if (wr && !rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (rd && !wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full)) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && empty)) else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count missed a write");

endmodule
`default_nettype wire

// ===== rtl/thsp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thsp_back
// Output register stage; expands paired entries into two items.
// ----------------------------------------------------------------------------
module thsp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire thsp_pkg::q_entry_t q_rdata,
    output logic                    q_rd,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output thsp_pkg::result_t       m_res
);
    import thsp_pkg::*;

    logic    valid_reg, valid_next;
    logic    pend_reg, pend_next;
    result_t res_reg, res_next;
    logic    adv;

    assign adv      = !valid_reg || m_tready;
    assign q_rd     = adv && !pend_reg && !q_empty;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        if (adv)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                res_next   = stop_result(ST_EXHAUSTED);
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                pend_next  = q_rdata.extra_stop;
                res_next   = q_rdata.res;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg) else $error("pending stop without a shown item");
    a_pend_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !q_rd) else $error("queue popped while a stop is pending");
    a_pend_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && m_tready) |=> (valid_reg && res_reg.kind == KIND_STOP))
        else $error("pending stop not shown next");

endmodule
`default_nettype wire

// ===== rtl/tar_header_stream_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tar_header_stream_parser_top
// ustar archive byte stream parser: header records, payload bytes, stops.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | content
//  s_*      | in        | s_tvalid/s_tready  | tdata: archive byte
//  m_*      | out       | m_tvalid/m_tready  | tuser: kind, tdata: record, tlast
//  cfg_*    | in        | cfg_we             | archive length
//
//  one archive byte is taken per cycle while the queue is not full; the front
//  parser updates its counters and accumulators in that cycle and writes at most
//  one queue entry; an entry carrying a trailing exhausted stop is shown as two
//  output items; results pass through an output register; the queue holds
//  QUEUE_DEPTH entries and s_tready drops only when it is full
//  asynchronous reset clears the parser to the header phase with zero length
// ----------------------------------------------------------------------------
module tar_header_stream_parser_top #(
    parameter int LENGTH_BITS = thsp_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = thsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [31:0]                 cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // data_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // status, entry_type, perm_bits, owner_id, group_id, file_size,
    // data_blocks, payload_byte, zero pad
    output logic [thsp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser,   // result_kind
    output logic                             m_tlast    // payload_last
);
    import thsp_pkg::*;

    q_entry_t q_wdata, q_rdata;
    logic     q_wr, q_rd, q_full, q_empty;
    result_t  res;

    thsp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata)
    );

    thsp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    thsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.plast;
    assign m_tdata = {6'd0, res.pbyte, res.blocks, res.size, res.gid, res.uid,
                      res.perm, res.etype, res.status};

endmodule
`default_nettype wire

// ===== dv/tar_header_stream_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_header_stream_parser_top_test
// Streams ustar archive images into the parser byte by byte and checks every
// header, payload and stop record against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module tar_header_stream_parser_top_test;
    import thsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    tar_header_stream_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // model state of the parser
    logic [31:0]       arch_len;
    logic [31:0]       left_bytes;
    phase_t            stage;
    logic [8:0]        hpos;
    logic [REC_W-1:0]  rec_left;
    logic [11:0]       acc_mode;
    logic [31:0]       acc_uid;
    logic [31:0]       acc_gid;
    logic [SIZE_W-1:0] acc_size;
    logic              fdone;
    logic              magic_good;
    logic              ver_good;
    logic [7:0]        tflag;

    result_t     expected_records[$];
    logic [7:0]  archive_bytes[$];
    bit          errors;
    bit          quiet_src;
    bit          quiet_sink;
    int          bytes_sent;
    int          records_seen;
    int          idle_cycles;

    function automatic void restart_parse();
        left_bytes = arch_len;
        stage      = PH_HEADER;
        hpos       = '0;
        rec_left   = '0;
        acc_mode   = '0;
        acc_uid    = '0;
        acc_gid    = '0;
        acc_size   = '0;
        fdone      = 1'b0;
        magic_good = 1'b1;
        ver_good   = 1'b1;
        tflag      = CH_NUL;
    endfunction

    function automatic logic [SIZE_W-1:0] octal_digit(input logic [SIZE_W-1:0] acc,
                                                      input logic [7:0] b,
                                                      input logic [SIZE_W-1:0] mask);
        if (fdone)
            return acc;
        if (b == CH_NUL || b == CH_SPACE)
        begin
            fdone = 1'b1;
            return acc;
        end
        return ((acc << 3) + SIZE_W'(b) - SIZE_W'(48)) & mask;
    endfunction

    function automatic bit plain_file();
        return tflag == CH_NUL || tflag == CH_ZERO || tflag == CH_SEVEN;
    endfunction

    function automatic logic [BLK_W-1:0] blocks_needed();
        logic [SIZE_W:0] rounded;
        if (tflag >= CH_ONE && tflag <= CH_SIX)
            return '0;
        rounded = {1'b0, acc_size} + 37'd511;
        return BLK_W'(rounded >> BLOCK_SHIFT);
    endfunction

    function automatic void push_stop(input status_t code);
        expected_records.push_back(stop_result(code));
        stage = PH_STOP;
    endfunction

    // advance the model by one accepted archive byte
    function automatic void predict_byte(input logic [7:0] b);
        result_t          r;
        logic [REC_W-1:0] off;
        logic [BLK_W-1:0] nblk;
        logic [2:0]       et;
        logic [7:0]       mch;
        if (stage == PH_STOP)
            return;
        if (stage == PH_DATA)
        begin
            off = REC_W'({9'd0, blocks_needed()} << BLOCK_SHIFT) - rec_left;
            if (plain_file() && off < {1'b0, acc_size})
            begin
                r       = '0;
                r.kind  = KIND_PAYLOAD;
                r.pbyte = b;
                r.plast = (off + 1'b1) == {1'b0, acc_size};
                expected_records.push_back(r);
            end
            rec_left   = rec_left - 1'b1;
            left_bytes = left_bytes - 1'b1;
            if (rec_left == '0)
            begin
                stage = PH_HEADER;
                hpos  = '0;
                if (left_bytes < 32'd512)
                    push_stop(ST_EXHAUSTED);
            end
            return;
        end
        if (hpos == '0)
        begin
            if (left_bytes < 32'd512)
            begin
                push_stop(ST_EXHAUSTED);
                return;
            end
            acc_mode   = '0;
            acc_uid    = '0;
            acc_gid    = '0;
            acc_size   = '0;
            fdone      = 1'b0;
            magic_good = 1'b1;
            ver_good   = 1'b1;
            tflag      = CH_NUL;
        end
        if (hpos == MODE_POS || hpos == UID_POS || hpos == GID_POS || hpos == SIZE_POS)
            fdone = 1'b0;
        if (hpos >= MODE_POS && hpos < UID_POS)
            acc_mode = 12'(octal_digit(SIZE_W'(acc_mode), b, 36'hFFF));
        else if (hpos >= UID_POS && hpos < GID_POS)
            acc_uid = 32'(octal_digit(SIZE_W'(acc_uid), b, 36'hFFFFFFFF));
        else if (hpos >= GID_POS && hpos < SIZE_POS)
            acc_gid = 32'(octal_digit(SIZE_W'(acc_gid), b, 36'hFFFFFFFF));
        else if (hpos >= SIZE_POS && hpos < SIZE_END)
            acc_size = octal_digit(acc_size, b, 36'hFFFFFFFFF);
        else if (hpos == TYPE_POS)
            tflag = b;
        else if (hpos >= MAGIC_POS && hpos < VER_POS)
        begin
            // the magic ends in a nul after "ustar"
            if (hpos == VER_POS - 9'd1)
                mch = CH_NUL;
            else
                mch = 8'(40'("ustar") >> (8 * (int'(VER_POS) - 2 - int'(hpos))));
            if (b != mch)
                magic_good = 1'b0;
        end
        else if (hpos >= VER_POS && hpos < VER_END)
        begin
            if (b != CH_ZERO)
                ver_good = 1'b0;
        end
        left_bytes = left_bytes - 1'b1;
        if (hpos != LAST_HDR_POS)
        begin
            hpos = hpos + 1'b1;
            return;
        end
        hpos = '0;
        if (!magic_good)
        begin
            push_stop(ST_BAD_MAGIC);
            return;
        end
        if (!ver_good)
        begin
            push_stop(ST_BAD_VER);
            return;
        end
        nblk = blocks_needed();
        if (plain_file())
            et = ET_REGULAR;
        else if (tflag >= CH_ONE && tflag <= CH_SIX)
            et = 3'(tflag - CH_ZERO);
        else
            et = ET_UNKNOWN;
        if ((64'(nblk) << BLOCK_SHIFT) > 64'(left_bytes))
        begin
            push_stop(ST_PAST_END);
            return;
        end
        r        = '0;
        r.kind   = KIND_HEADER;
        r.etype  = et;
        r.perm   = acc_mode & PERM_MASK;
        r.uid    = acc_uid;
        r.gid    = acc_gid;
        r.size   = acc_size;
        r.blocks = nblk;
        expected_records.push_back(r);
        if (nblk != '0)
        begin
            stage    = PH_DATA;
            rec_left = REC_W'(nblk) << BLOCK_SHIFT;
        end
        else if (left_bytes < 32'd512)
            push_stop(ST_EXHAUSTED);
    endfunction

    // ------------------------------------------------------------------
    // archive image construction
    // ------------------------------------------------------------------
    task automatic put_octal(inout logic [7:0] hdr[512], input int pos, input int len,
                             input logic [35:0] value, input bit space_term);
        for (int i = 0; i < len - 1; i++)
            hdr[pos + len - 2 - i] = CH_ZERO + 8'((value >> (3 * i)) & 36'h7);
        hdr[pos + len - 1] = space_term ? CH_SPACE : CH_NUL;
    endtask

    task automatic add_header(input logic [7:0] typ, input logic [11:0] mode,
                              input logic [31:0] uid, input logic [31:0] gid,
                              input logic [35:0] size, input bit bad_magic,
                              input bit bad_ver, input bit space_term);
        logic [7:0] hdr[512];
        for (int i = 0; i < 512; i++)
            hdr[i] = 8'($urandom);
        put_octal(hdr, 100, 8, 36'(mode), space_term);
        put_octal(hdr, 108, 8, 36'(uid) & 36'o7777777, space_term);
        put_octal(hdr, 116, 8, 36'(gid) & 36'o7777777, space_term);
        put_octal(hdr, 124, 12, size, space_term);
        hdr[156] = typ;
        hdr[257] = "u";
        hdr[258] = "s";
        hdr[259] = "t";
        hdr[260] = "a";
        hdr[261] = "r";
        hdr[262] = CH_NUL;
        hdr[263] = CH_ZERO;
        hdr[264] = CH_ZERO;
        if (bad_magic)
            hdr[$urandom_range(262, 257)] ^= 8'h01 << $urandom_range(7);
        if (bad_ver)
            hdr[$urandom_range(264, 263)] = 8'($urandom);
        foreach (hdr[i])
            archive_bytes.push_back(hdr[i]);
    endtask

    task automatic add_data(input logic [7:0] typ, input logic [35:0] size);
        int nbytes;
        if (typ >= CH_ONE && typ <= CH_SIX)
            return;
        nbytes = int'((size + 36'd511) >> 9) * 512;
        for (int i = 0; i < nbytes; i++)
            archive_bytes.push_back(8'($urandom));
    endtask

    task automatic add_record(input logic [7:0] typ, input logic [11:0] mode,
                              input logic [31:0] uid, input logic [31:0] gid,
                              input logic [35:0] size);
        add_header(typ, mode, uid, gid, size, 1'b0, 1'b0, $urandom_range(1));
        add_data(typ, size);
    endtask

    // ------------------------------------------------------------------
    // handshake helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while (!quiet_src && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        predict_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic stream_archive();
        while (archive_bytes.size() != 0)
            send_byte(archive_bytes.pop_front());
        s_tvalid <= 1'b0;
    endtask

    task automatic write_length(input logic [31:0] len);
        while (expected_records.size() != 0)
            @(negedge clk);
        // the last byte may still be in flight with no record behind it
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        arch_len = len;
        restart_parse();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // record checker, sink stalls and watchdog
    // ------------------------------------------------------------------
    always @(negedge clk)
        m_tready <= quiet_sink || ($urandom_range(99) >= 21);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{kind: m_tuser, status: m_tdata[2:0], etype: m_tdata[5:3],
                    perm: m_tdata[17:6], uid: m_tdata[49:18], gid: m_tdata[81:50],
                    size: m_tdata[117:82], blocks: m_tdata[145:118],
                    pbyte: m_tdata[153:146], plast: m_tlast};
            records_seen++;
            if (expected_records.size() == 0)
            begin
                $display("%0t: unexpected record %p", $realtime, got);
                errors = 1'b1;
            end
            else
            begin
                want = expected_records.pop_front();
                if (got !== want || m_tdata[159:154] !== '0)
                begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    errors = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_entry_types();
        // every type flag, sticky bit dropped, widest ids, empty files
        add_record("0", 12'o7777, 32'hFFFFFFFF, 32'd0, 36'd5);
        add_record("1", 12'o0644, 32'd1, 32'd2, 36'd100);
        add_record("2", 12'o1000, 32'd0, 32'hFFFFFFFF, 36'd0);
        add_record("3", 12'o4755, 32'd7, 32'd8, 36'd3);
        add_record("4", 12'o2000, 32'd9, 32'd10, 36'd0);
        add_record("5", 12'o0755, 32'd11, 32'd12, 36'd0);
        add_record("6", 12'o0600, 32'd13, 32'd14, 36'd0);
        add_record("x", 12'o0777, 32'd15, 32'd16, 36'd1);
        add_record("7", 12'o0640, 32'd17, 32'd18, 36'd512);
        add_record(CH_NUL, 12'o0000, 32'd0, 32'd0, 36'd513);
        write_length(32'(archive_bytes.size()));
        stream_archive();
    endtask

    task automatic test_stops();
        // trailer of zero blocks with the largest length
        add_record("0", 12'o0644, 32'd1, 32'd1, 36'd20);
        for (int i = 0; i < 1024; i++)
            archive_bytes.push_back(CH_NUL);
        write_length(32'hFFFFFFFF);
        stream_archive();
        // bad version
        add_header("0", 12'o0644, 32'd1, 32'd1, 36'd0, 1'b0, 1'b1, 1'b0);
        write_length(32'd4096);
        stream_archive();
        // bad magic and bad version together: magic wins
        add_header("0", 12'o0644, 32'd1, 32'd1, 36'd0, 1'b1, 1'b1, 1'b0);
        write_length(32'd4096);
        stream_archive();
        // record past the end with the largest size field
        add_header("0", 12'o0644, 32'd1, 32'd1, 36'o77777777777, 1'b0, 1'b0, 1'b0);
        write_length(32'd1024);
        stream_archive();
        // archive too short to hold a header from the start
        archive_bytes.push_back(8'hFF);
        archive_bytes.push_back(8'h00);
        write_length(32'd0);
        stream_archive();
        // junk in numeric fields and overflowing digits
        add_header("0", 12'o0644, 32'd1, 32'd1, 36'd7, 1'b0, 1'b0, 1'b0);
        for (int i = 100; i < 136; i++)
            archive_bytes[i] = (i % 3 == 0) ? 8'hFF : "9";
        archive_bytes[127] = CH_NUL;
        write_length(32'd511 + 32'd512);
        stream_archive();
    endtask

    task automatic test_random_archives();
        int         nrec;
        int         mode_sel;
        logic [7:0] typ;
        logic [35:0] size;
        while (bytes_sent < 1150)
        begin
            nrec = $urandom_range(3);
            for (int e = 0; e < nrec; e++)
            begin
                case ($urandom_range(9))
                    0: typ = "1" + 8'($urandom_range(5));
                    1: typ = 8'($urandom);
                    2: typ = CH_NUL;
                    default: typ = "0";
                endcase
                size = ($urandom_range(19) == 0) ? 36'($urandom_range(4000))
                                                 : 36'($urandom_range(700));
                if ($urandom_range(9) == 0)
                begin
                    add_header(typ, 12'($urandom), $urandom, $urandom, size,
                               $urandom_range(7) == 0, $urandom_range(7) == 0,
                               $urandom_range(1));
                    // scribble over a numeric field now and then
                    archive_bytes[archive_bytes.size() - 512 + $urandom_range(135, 100)]
                        = 8'($urandom);
                    add_data(typ, size);
                end
                else
                    add_record(typ, 12'($urandom), $urandom, $urandom, size);
            end
            if ($urandom_range(1))
                for (int i = 0; i < 1024; i++)
                    archive_bytes.push_back(CH_NUL);
            mode_sel = $urandom_range(3);
            case (mode_sel)
                0: write_length(32'(archive_bytes.size()));
                1: write_length(32'(archive_bytes.size() + $urandom_range(700)));
                2: write_length(32'($urandom_range(archive_bytes.size())));
                default: write_length($urandom);
            endcase
            // some bytes past any stop are ignored
            repeat ($urandom_range(4))
                archive_bytes.push_back(8'($urandom));
            quiet_src  = ($urandom_range(5) == 0);
            quiet_sink = quiet_src;
            stream_archive();
            quiet_src  = 1'b0;
            quiet_sink = 1'b0;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        errors       = 1'b0;
        quiet_src    = 1'b0;
        quiet_sink   = 1'b0;
        bytes_sent   = 0;
        records_seen = 0;
        idle_cycles  = 0;
        arch_len     = '0;
        restart_parse();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_entry_types();
        test_stops();
        test_random_archives();

        while (expected_records.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (!errors && expected_records.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== tar_header_stream_parser_top.f =====
rtl/thsp_pkg.sv
rtl/thsp_front.sv
rtl/thsp_queue.sv
rtl/thsp_back.sv
rtl/tar_header_stream_parser_top.sv
dv/tar_header_stream_parser_top_test.sv
